>>> src/rpas_pkg.sv
// ----------------------------------------------------------------------------
// rpas_pkg
// Shared constants and nibble-level functions for the ROM address/data
// scrambler: cipher tables, round constants, action codes.
// ----------------------------------------------------------------------------
package rpas_pkg;

    typedef logic [3:0]  t_nib;
    typedef logic [63:0] t_blk;
    typedef logic [1:0]  t_action;

    localparam t_action ACT_SCRAMBLE   = 2'd0;
    localparam t_action ACT_DESCRAMBLE = 2'd1;
    localparam t_action ACT_RAW        = 2'd2;

    localparam t_nib SB_FWD [16] = '{4'hb, 4'hf, 4'h3, 4'h2, 4'ha, 4'hc, 4'h9, 4'h1,
                                     4'h6, 4'h7, 4'h8, 4'h0, 4'he, 4'h5, 4'hd, 4'h4};
    localparam t_nib SB_INV [16] = '{4'hb, 4'h7, 4'h3, 4'h2, 4'hf, 4'hd, 4'h8, 4'h9,
                                     4'ha, 4'h6, 4'h4, 4'h0, 4'h5, 4'he, 4'hc, 4'h1};
    localparam t_nib ROW_FWD [16] = '{4'd4, 4'd9, 4'd14, 4'd3, 4'd8, 4'd13, 4'd2, 4'd7,
                                      4'd12, 4'd1, 4'd6, 4'd11, 4'd0, 4'd5, 4'd10, 4'd15};
    localparam t_nib ROW_INV [16] = '{4'd12, 4'd9, 4'd6, 4'd3, 4'd0, 4'd13, 4'd10, 4'd7,
                                      4'd4, 4'd1, 4'd14, 4'd11, 4'd8, 4'd5, 4'd2, 4'd15};
    localparam t_nib PRESENT_SB [16] = '{4'hc, 4'h5, 4'h6, 4'hb, 4'h9, 4'h0, 4'ha, 4'hd,
                                         4'h3, 4'he, 4'hf, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2};

    localparam logic [15:0] MIX_MASK [4] = '{16'h7bde, 16'hbde7, 16'hde7b, 16'he7bd};

    localparam t_blk RCONST [12] = '{
        64'h0000000000000000, 64'h13198a2e03707344, 64'ha4093822299f31d0,
        64'h082efa98ec4e6c89, 64'h452821e638d01377, 64'hbe5466cf34e90c6c,
        64'h7ef84f78fd955cb1, 64'h85840851f1ac43aa, 64'hc882d32f25323c54,
        64'h64a51195e0e3610d, 64'hd3b5a399ca0c2399, 64'hc0ac29b7c97c50dd
    };

    function automatic t_blk nib_sub_fwd(input t_blk v);
        t_blk r;
        r = '0;
        for (int i = 0; i < 16; i++) begin
            r[4*i +: 4] = SB_FWD[v[4*i +: 4]];
        end
        return r;
    endfunction

    function automatic t_blk nib_sub_inv(input t_blk v);
        t_blk r;
        r = '0;
        for (int i = 0; i < 16; i++) begin
            r[4*i +: 4] = SB_INV[v[4*i +: 4]];
        end
        return r;
    endfunction

    function automatic t_blk nib_perm_fwd(input t_blk v);
        t_blk r;
        r = '0;
        for (int i = 0; i < 16; i++) begin
            r[4*i +: 4] = v[4*int'(ROW_FWD[i]) +: 4];
        end
        return r;
    endfunction

    function automatic t_blk nib_perm_inv(input t_blk v);
        t_blk r;
        r = '0;
        for (int i = 0; i < 16; i++) begin
            r[4*i +: 4] = v[4*int'(ROW_INV[i]) +: 4];
        end
        return r;
    endfunction

    function automatic t_nib fold16(input logic [15:0] v);
        return v[3:0] ^ v[7:4] ^ v[11:8] ^ v[15:12];
    endfunction

    function automatic t_blk mix_layer(input t_blk v);
        t_blk        r;
        logic [15:0] half;
        logic [1:0]  start;
        logic [1:0]  sel;
        r = '0;
        for (int blk = 0; blk < 4; blk++) begin
            half  = v[16*blk +: 16];
            start = (blk == 0 || blk == 3) ? 2'd0 : 2'd1;
            for (int n = 0; n < 4; n++) begin
                sel = start + 2'd3 - 2'(n);
                r[16*blk + 4*n +: 4] = fold16(half & MIX_MASK[sel]);
            end
        end
        return r;
    endfunction

endpackage

>>> src/rpas_addr_perm.sv
// ----------------------------------------------------------------------------
// rpas_addr_perm
// Logical to physical word address: rounds of PRESENT sbox, bit reverse and
// even/odd butterfly.
// ----------------------------------------------------------------------------
module rpas_addr_perm #(
    parameter int ADDR_BITS   = 13,
    parameter int PERM_ROUNDS = 2
) (
    input  logic [ADDR_BITS-1:0] i_addr,
    output logic [ADDR_BITS-1:0] o_addr
);

    localparam int NIBS = ADDR_BITS / 4;
    localparam int HALF = ADDR_BITS / 2;

    logic [ADDR_BITS-1:0] w_stage [PERM_ROUNDS+1];

    assign w_stage[0] = i_addr;

    for (genvar r = 0; r < PERM_ROUNDS; r++) begin : g_round
        logic [ADDR_BITS-1:0] w_sub;
        logic [ADDR_BITS-1:0] w_rev;
        logic [ADDR_BITS-1:0] w_bf;

        always_comb begin
            w_sub = w_stage[r];
            for (int i = 0; i < NIBS; i++) begin
                w_sub[4*i +: 4] = rpas_pkg::PRESENT_SB[w_stage[r][4*i +: 4]];
            end
            for (int i = 0; i < ADDR_BITS; i++) begin
                w_rev[i] = w_sub[ADDR_BITS-1-i];
            end
            // unpaired top bit on odd widths stays in place
            w_bf = w_rev;
            for (int i = 0; i < HALF; i++) begin
                w_bf[i]        = w_rev[2*i];
                w_bf[HALF + i] = w_rev[2*i + 1];
            end
        end

        assign w_stage[r+1] = w_bf;
    end

    assign o_addr = w_stage[PERM_ROUNDS];

endmodule

>>> src/rpas_keystream.sv
// ----------------------------------------------------------------------------
// rpas_keystream
// Zero-key PRINCE over the logical address, unrolled half-rounds, cut to the
// word width.
// ----------------------------------------------------------------------------
module rpas_keystream #(
    parameter int ADDR_BITS   = 13,
    parameter int WORD_BITS   = 39,
    parameter int HALF_ROUNDS = 3
) (
    input  logic [ADDR_BITS-1:0] i_addr,
    output logic [WORD_BITS-1:0] o_key
);

    rpas_pkg::t_blk w_fwd [HALF_ROUNDS+1];
    rpas_pkg::t_blk w_bwd [HALF_ROUNDS+1];
    rpas_pkg::t_blk w_last;

    assign w_fwd[0] = 64'(i_addr) ^ rpas_pkg::RCONST[0];

    for (genvar h = 0; h < HALF_ROUNDS; h++) begin : g_fwd
        localparam int RCI = (1 + h) % 12;
        assign w_fwd[h+1] = rpas_pkg::nib_perm_fwd(rpas_pkg::mix_layer(
                                rpas_pkg::nib_sub_fwd(w_fwd[h]))) ^ rpas_pkg::RCONST[RCI];
    end

    assign w_bwd[0] = rpas_pkg::nib_sub_inv(rpas_pkg::mix_layer(
                          rpas_pkg::nib_sub_fwd(w_fwd[HALF_ROUNDS])));

    for (genvar h = 0; h < HALF_ROUNDS; h++) begin : g_bwd
        localparam int RCI = (11 - HALF_ROUNDS + h) % 12;
        assign w_bwd[h+1] = rpas_pkg::nib_sub_inv(rpas_pkg::mix_layer(
                                rpas_pkg::nib_perm_inv(w_bwd[h] ^ rpas_pkg::RCONST[RCI])));
    end

    assign w_last = w_bwd[HALF_ROUNDS] ^ rpas_pkg::RCONST[11];
    assign o_key  = w_last[WORD_BITS-1:0];

endmodule

>>> src/rom_prince_address_data_scrambler.sv
// ----------------------------------------------------------------------------
// rom_prince_address_data_scrambler
// ROM address and data scrambler: SP-network address map, PRINCE keystream.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_stall) carries an action, a logical word address
// and a data word; a transfer happens on a clock edge with i_valid high and
// o_stall low. Output channel (o_valid / i_stall) returns one result per
// input: the physical address and the scrambled, descrambled or raw word.
// Path from input transfer to o_valid: an input register, one pass through
// the address network and the keystream cipher, and a result register.
// Throughput is one item per cycle when i_stall is low, set by that pass.
// While i_stall holds a valid result, the result stays put and one more item
// can still be taken into the input register; o_stall rises only once both
// registers are full and the output is stalled.
// Synchronous active-low reset empties both registers; no other state.
// Action code 3 is handled as raw placement.
// ----------------------------------------------------------------------------
module rom_prince_address_data_scrambler #(
    parameter int ADDR_BITS   = 13,
    parameter int WORD_BITS   = 39,
    parameter int HALF_ROUNDS = 3,
    parameter int PERM_ROUNDS = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [1:0]           i_action,
    input  logic [ADDR_BITS-1:0] i_logical_address,
    input  logic [WORD_BITS-1:0] i_data_word,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [ADDR_BITS-1:0] o_physical_address,
    output logic [WORD_BITS-1:0] o_out_word
);

    localparam logic [WORD_BITS-1:0] LOW32 = WORD_BITS'(64'hffff_ffff);

    logic                  r_in_valid;
    logic                  r_out_valid;
    rpas_pkg::t_action     r_action;
    logic [ADDR_BITS-1:0]  r_addr;
    logic [WORD_BITS-1:0]  r_word;
    logic [ADDR_BITS-1:0]  r_phys;
    logic [WORD_BITS-1:0]  r_res;

    logic                  n_in_valid;
    logic                  n_out_valid;
    logic [WORD_BITS-1:0]  n_res;
    logic [ADDR_BITS-1:0]  n_phys;

    logic                  w_take;
    logic                  w_adv;
    logic [WORD_BITS-1:0]  w_key;

    assign w_adv       = r_in_valid & (~r_out_valid | ~i_stall);
    assign o_stall     = r_in_valid & ~w_adv;
    assign w_take      = i_valid & ~o_stall;
    assign n_in_valid  = w_take | (r_in_valid & ~w_adv);
    assign n_out_valid = w_adv | (r_out_valid & i_stall);

    rpas_addr_perm #(
        .ADDR_BITS   (ADDR_BITS),
        .PERM_ROUNDS (PERM_ROUNDS)
    ) u_addr_perm (
        .i_addr (r_addr),
        .o_addr (n_phys)
    );

    rpas_keystream #(
        .ADDR_BITS   (ADDR_BITS),
        .WORD_BITS   (WORD_BITS),
        .HALF_ROUNDS (HALF_ROUNDS)
    ) u_keystream (
        .i_addr (r_addr),
        .o_key  (w_key)
    );

    always_comb begin
        unique case (r_action)
            rpas_pkg::ACT_SCRAMBLE:   n_res = w_key ^ (r_word & LOW32);
            rpas_pkg::ACT_DESCRAMBLE: n_res = (w_key ^ r_word) & LOW32;
            default:                  n_res = r_word;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_action <= i_action;
            r_addr   <= i_logical_address;
            r_word   <= i_data_word;
        end
        if (w_adv) begin
            r_phys <= n_phys;
            r_res  <= n_res;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_physical_address = r_phys;
    assign o_out_word         = r_res;

endmodule

>>> src/rpas_checker.sv
// ----------------------------------------------------------------------------
// rpas_checker
// Port-level checks for the ROM scrambler, bound to the top level.
// ----------------------------------------------------------------------------
module rpas_checker #(
    parameter int ADDR_BITS = 13,
    parameter int WORD_BITS = 39
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 o_stall,
    input logic                 o_valid,
    input logic                 i_stall,
    input logic [ADDR_BITS-1:0] o_physical_address,
    input logic [WORD_BITS-1:0] o_out_word
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while output can move");

    a_transfer_arrives: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |-> ##2 o_valid)
        else $error("accepted transfer did not reach the output");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=>
            (o_valid && $stable(o_out_word) && $stable(o_physical_address)))
        else $error("stalled result changed");

endmodule

bind rom_prince_address_data_scrambler rpas_checker #(
    .ADDR_BITS (ADDR_BITS),
    .WORD_BITS (WORD_BITS)
) u_rpas_checker (.*);
